// ----- hw/rtl/idnr_pkg.sv -----
// idnr_pkg: shared types and constants for the int8 dense neuron requantize block
// used by idnr_front, idnr_fifo, idnr_back and int8_dense_neuron_requantize
`timescale 1ns / 1ps

package idnr_pkg;

  localparam int unsigned IdnrFifoDepth = 2;
  localparam int unsigned AccW          = 32;
  localparam int unsigned CfgIdxW       = 2;

  localparam logic [CfgIdxW-1:0] REG_MULT  = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_SHIFT = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_LOW   = 2'd2;
  localparam logic [CfgIdxW-1:0] REG_HIGH  = 2'd3;

  localparam logic signed [31:0] MULT_RESET  = 32'sh4000_0000;
  localparam logic signed [5:0]  SHIFT_RESET = -6'sd11;
  localparam logic signed [7:0]  LOW_RESET   = 8'sd0;
  localparam logic signed [7:0]  HIGH_RESET  = 8'sd127;

  localparam logic signed [31:0] WORD_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] WORD_MAX = 32'sh7fff_ffff;

  typedef struct packed {
    logic signed [31:0] mult;
    logic signed [5:0]  shift;
    logic signed [7:0]  low;
    logic signed [7:0]  high;
  } cfg_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

  typedef struct packed {
    logic idle;
    logic pop;
  } back_stat_t;

endpackage

// ----- hw/rtl/int8_dense_neuron_requantize.sv -----
// int8_dense_neuron_requantize: top level, config registers and the front/queue/back split
// depends on idnr_pkg, idnr_front, idnr_fifo, idnr_back
//
// channel  direction  handshake               payload
// in       input      in_valid_i / in_stall_o  activation_i weight_i bias_i first_i last_i
// out      output     out_valid_o / out_stall_i neuron_out_o
// cfg      input      cfg_we_i                cfg_idx_i cfg_data_i
//
// one multiply-accumulate per cycle: an item is taken every cycle while the queue has room
// each neuron sum passes in turn through the requantize sequencer's shift, multiply,
// rounding, divide, rounding-shift and clamp steps; the queue holds FifoDepth sums
// in_stall_o rises only when the queue is full; out_stall_i holds the result register
// and the sequencer waits in its clamp step until that register is free
// reset clears the accumulator, queue pointers, sequencer state and config to defaults
`timescale 1ns / 1ps

module int8_dense_neuron_requantize
  import idnr_pkg::*;
#(
  parameter int unsigned FifoDepth = IdnrFifoDepth
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic signed [7:0]      activation_i,
  input  logic signed [7:0]      weight_i,
  input  logic signed [AccW-1:0] bias_i,
  input  logic                   first_i,
  input  logic                   last_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic signed [7:0]      neuron_out_o,
  input  logic                   cfg_we_i,
  input  logic [CfgIdxW-1:0]     cfg_idx_i,
  input  logic [31:0]            cfg_data_i
);

  cfg_t            cfg_q;
  fifo_stat_t      fifo_stat;
  back_stat_t      bk_stat;
  logic            push;
  logic [AccW-1:0] push_data;
  logic [AccW-1:0] pop_data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mult  <= MULT_RESET;
      cfg_q.shift <= SHIFT_RESET;
      cfg_q.low   <= LOW_RESET;
      cfg_q.high  <= HIGH_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_MULT:  cfg_q.mult  <= cfg_data_i;
        REG_SHIFT: cfg_q.shift <= cfg_data_i[5:0];
        REG_LOW:   cfg_q.low   <= cfg_data_i[7:0];
        REG_HIGH:  cfg_q.high  <= cfg_data_i[7:0];
        default: begin
        end
      endcase
    end
  end

  idnr_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .activation_i (activation_i),
    .weight_i     (weight_i),
    .bias_i       (bias_i),
    .first_i      (first_i),
    .last_i       (last_i),
    .fifo_stat_i  (fifo_stat),
    .push_o       (push),
    .push_data_o  (push_data)
  );

  idnr_fifo #(
    .Depth (FifoDepth),
    .Width (AccW)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (bk_stat.pop),
    .pop_data_o  (pop_data),
    .stat_o      (fifo_stat)
  );

  idnr_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .fifo_stat_i  (fifo_stat),
    .pop_data_i   (pop_data),
    .stat_o       (bk_stat),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .neuron_out_o (neuron_out_o)
  );

  // a last transfer always leaves a sum waiting in the queue
  a_last_queued: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && last_i) |=> !fifo_stat.empty)
    else $error("last transfer did not reach the queue");

  // the sequencer picks up a waiting sum right away
  a_back_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (bk_stat.idle && !fifo_stat.empty) |=> !bk_stat.idle)
    else $error("sequencer did not start on a queued sum");

  // a new result comes only from a running sequence
  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!bk_stat.idle))
    else $error("result appeared without a requantize sequence");

  // no pop from an empty queue
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bk_stat.pop |-> !fifo_stat.empty)
    else $error("pop from empty queue");

endmodule

// ----- hw/rtl/idnr_front.sv -----
// idnr_front: accepts input transfers and runs the multiply-accumulate
// depends on idnr_pkg; pushes finished neuron sums into idnr_fifo
`timescale 1ns / 1ps

module idnr_front
  import idnr_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic signed [7:0]      activation_i,
  input  logic signed [7:0]      weight_i,
  input  logic signed [AccW-1:0] bias_i,
  input  logic                   first_i,
  input  logic                   last_i,
  input  fifo_stat_t             fifo_stat_i,
  output logic                   push_o,
  output logic [AccW-1:0]        push_data_o
);

  logic [AccW-1:0]    acc_q, acc_d;
  logic signed [15:0] prod;
  logic               accept;

  assign accept     = in_valid_i && !fifo_stat_i.full;
  assign in_stall_o = fifo_stat_i.full;
  assign prod       = activation_i * weight_i;

  always_comb begin
    acc_d = (first_i ? bias_i : acc_q) + {{(AccW-16){prod[15]}}, prod};
  end

  assign push_o      = accept && last_i;
  assign push_data_o = acc_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else if (accept) begin
      acc_q <= acc_d;
    end
  end

endmodule

// ----- hw/rtl/idnr_fifo.sv -----
// idnr_fifo: short queue of neuron sums between front and back
// depends on idnr_pkg for the status struct
`timescale 1ns / 1ps

module idnr_fifo
  import idnr_pkg::*;
#(
  parameter int unsigned Depth = IdnrFifoDepth,
  parameter int unsigned Width = AccW
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] push_data_i,
  input  logic             pop_i,
  output logic [Width-1:0] pop_data_o,
  output fifo_stat_t       stat_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  cnt_q;

  assign stat_o.full  = (cnt_q == FullCnt);
  assign stat_o.empty = (cnt_q == '0);
  assign pop_data_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

// ----- hw/rtl/idnr_back.sv -----
// idnr_back: requantize sequencer (shift, high multiply, rounding shift, clamp)
// depends on idnr_pkg; pops sums from idnr_fifo and holds the output register
`timescale 1ns / 1ps

module idnr_back
  import idnr_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  cfg_t                  cfg_i,
  input  fifo_stat_t            fifo_stat_i,
  input  logic [AccW-1:0]       pop_data_i,
  output back_stat_t            stat_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic signed [7:0]     neuron_out_o
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MUL  = 3'd1;
  localparam logic [2:0] ST_RND  = 3'd2;
  localparam logic [2:0] ST_DIV  = 3'd3;
  localparam logic [2:0] ST_SHR  = 3'd4;
  localparam logic [2:0] ST_OUT  = 3'd5;

  logic [2:0] state_q, state_d;

  logic signed [31:0] x_q, x_d;
  logic signed [63:0] p_q, p_d;
  logic signed [63:0] r_q, r_d;
  logic               sat_q, sat_d;
  logic signed [31:0] hm_q, hm_d;
  logic signed [32:0] fl_q, fl_d;
  logic [32:0]        rem_q, rem_d;
  logic [32:0]        thr_q, thr_d;
  logic               out_valid_q, out_valid_d;
  logic signed [7:0]  out_q, out_d;

  logic               sh_pos;
  logic [4:0]         ls;
  logic [5:0]         rs;
  logic signed [32:0] qs;
  logic               corr;
  logic signed [32:0] hm_ext;
  logic [32:0]        mask;
  logic signed [32:0] v;
  logic signed [32:0] lo_ext, hi_ext;
  logic               pop;
  logic               out_free;

  assign sh_pos   = !cfg_i.shift[5] && (cfg_i.shift != '0);
  assign ls       = sh_pos ? cfg_i.shift[4:0] : 5'd0;
  assign rs       = sh_pos ? 6'd0 : (6'd0 - cfg_i.shift);
  assign pop      = (state_q == ST_IDLE) && !fifo_stat_i.empty;
  assign out_free = !out_valid_q || !out_stall_i;

  assign qs     = r_q[63:31];
  assign corr   = r_q[63] && (r_q[30:0] != '0);
  assign hm_ext = {hm_q[31], hm_q};
  assign mask   = (33'd1 << rs) - 33'd1;
  assign v      = fl_q + ((rem_q > thr_q) ? 33'sd1 : 33'sd0);
  assign lo_ext = {{25{cfg_i.low[7]}}, cfg_i.low};
  assign hi_ext = {{25{cfg_i.high[7]}}, cfg_i.high};

  always_comb begin
    state_d     = state_q;
    x_d         = x_q;
    p_d         = p_q;
    r_d         = r_q;
    sat_d       = sat_q;
    hm_d        = hm_q;
    fl_d        = fl_q;
    rem_d       = rem_q;
    thr_d       = thr_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    case (state_q)
      ST_IDLE: begin
        if (pop) begin
          x_d     = pop_data_i << ls;
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        p_d     = x_q * cfg_i.mult;
        sat_d   = (x_q == WORD_MIN) && (cfg_i.mult == WORD_MIN);
        state_d = ST_RND;
      end
      ST_RND: begin
        r_d     = p_q + (p_q[63] ? (64'sd1 - 64'sh4000_0000) : 64'sh4000_0000);
        state_d = ST_DIV;
      end
      ST_DIV: begin
        hm_d    = sat_q ? WORD_MAX : (qs[31:0] + {31'd0, corr});
        state_d = ST_SHR;
      end
      ST_SHR: begin
        fl_d    = hm_ext >>> rs;
        rem_d   = {1'b0, hm_q} & mask;
        thr_d   = (mask >> 1) + {32'd0, hm_q[31]};
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (out_free) begin
          if (v < lo_ext) begin
            out_d = cfg_i.low;
          end else if (v > hi_ext) begin
            out_d = cfg_i.high;
          end else begin
            out_d = v[7:0];
          end
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    x_q   <= x_d;
    p_q   <= p_d;
    r_q   <= r_d;
    sat_q <= sat_d;
    hm_q  <= hm_d;
    fl_q  <= fl_d;
    rem_q <= rem_d;
    thr_q <= thr_d;
    out_q <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign stat_o.idle  = (state_q == ST_IDLE);
  assign stat_o.pop   = pop;
  assign out_valid_o  = out_valid_q;
  assign neuron_out_o = out_q;

endmodule
